// ----- src/pimr_pkg.sv -----
// Package for the point-in-mesh ray parity unit.
// Holds fixed ray direction, datapath widths, config codes and queue types.
// No dependencies.
package pimr_pkg;

  // Ray direction (1, 0.4123, 0.7182) normalized, Q1.30
  localparam int DIR_W = 31;
  localparam logic signed [DIR_W-1:0] DIR_X = 31'sd826982886;
  localparam logic signed [DIR_W-1:0] DIR_Y = 31'sd340965041;
  localparam logic signed [DIR_W-1:0] DIR_Z = 31'sd593939109;

  localparam int COORD_W = 32;
  localparam int EDGE_W  = 33;   // vertex differences
  localparam int PR_W    = 34;   // D x E2 and E1 x D after >>> 30
  localparam int N_W     = 51;   // E1 x E2 after >>> 16
  localparam int DOT_W   = 70;   // det, un, vn
  localparam int TN_W    = 88;   // tn
  localparam int CMP_W   = 104;  // tn << 16 against min_dist * det
  localparam int NSPLIT  = 25;   // low slice of N for split multiply

  localparam int MIN_W  = 16;
  localparam int HITS_W = 16;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;

  localparam int COUNT_BITS_DEF = 16;
  localparam int QDEPTH_DEF     = 16;
  localparam int FRONT_STAGES   = 7;

  // Config register indexes
  localparam logic [IDX_W-1:0] REG_POINT_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_POINT_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_POINT_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_DET  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_DIST = 3'd4;

  // Verdict for one triangle as queued between front and back
  typedef struct packed {
    logic hit;
    logic last;
  } verdict_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic room;
    logic empty;
  } qstat_t;

endpackage

// ----- src/pimr_if.sv -----
// Channel interfaces of the point-in-mesh ray parity unit.
// Depends on pimr_pkg for field widths.
interface pimr_tri_if;
  logic valid;
  logic ready;
  logic signed [pimr_pkg::COORD_W-1:0] a_x, a_y, a_z;
  logic signed [pimr_pkg::COORD_W-1:0] b_x, b_y, b_z;
  logic signed [pimr_pkg::COORD_W-1:0] c_x, c_y, c_z;
  logic final_tri;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  final_tri, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  final_tri, output ready);
endinterface

interface pimr_res_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic [pimr_pkg::HITS_W-1:0] hits;

  modport source (output valid, inside_res, hits, input ready);
  modport sink   (input valid, inside_res, hits, output ready);
endinterface

// ----- src/pimr_front.sv -----
// Front pipeline: Moller-Trumbore test of one triangle per cycle, 7 stages.
// Depends on pimr_pkg. Never stalls; the queue credit keeps it from overrunning.
module pimr_front (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic signed [pimr_pkg::COORD_W-1:0] va [3],
  input  logic signed [pimr_pkg::COORD_W-1:0] vb [3],
  input  logic signed [pimr_pkg::COORD_W-1:0] vc [3],
  input  logic last_in,
  input  logic signed [pimr_pkg::COORD_W-1:0] qp [3],
  input  logic [pimr_pkg::MIN_W-1:0] min_det,
  input  logic [pimr_pkg::MIN_W-1:0] min_dist,
  output logic push,
  output pimr_pkg::verdict_t verdict
);
  localparam int NS = pimr_pkg::FRONT_STAGES;
  localparam int EW = pimr_pkg::EDGE_W;
  localparam int DW = pimr_pkg::DOT_W;
  localparam int TW = pimr_pkg::TN_W;
  localparam int NL = pimr_pkg::NSPLIT;
  localparam int NH = pimr_pkg::N_W - NL;
  localparam int DL = 35;   // low slice of det for the min_dist product

  logic [NS-1:0] vld;
  logic [NS-1:0] lst;

  logic signed [pimr_pkg::DIR_W-1:0] dir [3];
  assign dir[0] = pimr_pkg::DIR_X;
  assign dir[1] = pimr_pkg::DIR_Y;
  assign dir[2] = pimr_pkg::DIR_Z;

  // stage 1: edges and offset
  logic signed [EW-1:0] e1_1 [3], e2_1 [3], s_1 [3];
  // stage 2: cross-product terms
  logic signed [63:0] pa_2 [3], pb_2 [3], ra_2 [3], rb_2 [3];
  logic signed [65:0] na_2 [3], nb_2 [3];
  logic signed [EW-1:0] e1_2 [3], s_2 [3];
  // stage 3: P, R, N
  logic signed [pimr_pkg::PR_W-1:0] p_3 [3], r_3 [3];
  logic signed [pimr_pkg::N_W-1:0] n_3 [3];
  logic signed [EW-1:0] e1_3 [3], s_3 [3];
  // stage 4: dot-product terms
  logic signed [66:0] dp_4 [3], up_4 [3], vp_4 [3];
  logic signed [EW+NL:0] tl_4 [3];
  logic signed [EW+NH-1:0] th_4 [3];
  // stage 5: sums
  logic signed [DW-1:0] det_5, un_5, vn_5;
  logic signed [TW-1:0] tn_5;
  // stage 6: sign folded
  logic signed [DW-1:0] det_6, un_6, vn_6;
  logic signed [TW-1:0] tn_6;
  // stage 7: range checks and min_dist product, det split in two halves
  logic ok_7;
  logic signed [TW-1:0] tn_7;
  logic [DL+pimr_pkg::MIN_W-1:0] mdl_7;
  logic [DW-DL+pimr_pkg::MIN_W-1:0] mdh_7;

  logic signed [DW:0] uv_6;
  logic signed [pimr_pkg::CMP_W-1:0] lhs_8, rhs_8;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-2:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    lst <= {lst[NS-2:0], last_in};
  end

  for (genvar k = 0; k < 3; k++) begin : g_vec
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    always_ff @(posedge clk) begin
      e1_1[k] <= EW'(vb[k]) - EW'(va[k]);
      e2_1[k] <= EW'(vc[k]) - EW'(va[k]);
      s_1[k]  <= EW'(qp[k]) - EW'(va[k]);

      pa_2[k] <= dir[K1] * e2_1[K2];
      pb_2[k] <= dir[K2] * e2_1[K1];
      ra_2[k] <= e1_1[K1] * dir[K2];
      rb_2[k] <= e1_1[K2] * dir[K1];
      na_2[k] <= e1_1[K1] * e2_1[K2];
      nb_2[k] <= e1_1[K2] * e2_1[K1];
      e1_2[k] <= e1_1[k];
      s_2[k]  <= s_1[k];

      p_3[k]  <= pimr_pkg::PR_W'((pa_2[k] - pb_2[k]) >>> 30);
      r_3[k]  <= pimr_pkg::PR_W'((ra_2[k] - rb_2[k]) >>> 30);
      n_3[k]  <= pimr_pkg::N_W'((67'(na_2[k]) - 67'(nb_2[k])) >>> 16);
      e1_3[k] <= e1_2[k];
      s_3[k]  <= s_2[k];

      dp_4[k] <= e1_3[k] * p_3[k];
      up_4[k] <= s_3[k] * p_3[k];
      vp_4[k] <= s_3[k] * r_3[k];
      tl_4[k] <= s_3[k] * $signed({1'b0, n_3[k][NL-1:0]});
      th_4[k] <= s_3[k] * $signed(n_3[k][pimr_pkg::N_W-1:NL]);
    end
  end

  assign uv_6 = (DW+1)'(un_6) + (DW+1)'(vn_6);
  assign lhs_8 = pimr_pkg::CMP_W'(tn_7) <<< 16;
  // det is never negative after the fold, so both halves are plain magnitudes
  assign rhs_8 = $signed((pimr_pkg::CMP_W'(mdh_7) << DL) + pimr_pkg::CMP_W'(mdl_7));

  always_ff @(posedge clk) begin
    det_5 <= DW'(dp_4[0]) + DW'(dp_4[1]) + DW'(dp_4[2]);
    un_5  <= DW'(up_4[0]) + DW'(up_4[1]) + DW'(up_4[2]);
    vn_5  <= DW'(vp_4[0]) + DW'(vp_4[1]) + DW'(vp_4[2]);
    tn_5  <= ((TW'(th_4[0]) + TW'(th_4[1]) + TW'(th_4[2])) <<< NL)
           + TW'(tl_4[0]) + TW'(tl_4[1]) + TW'(tl_4[2]);

    if (det_5[DW-1]) begin
      det_6 <= -det_5;
      un_6  <= -un_5;
      vn_6  <= -vn_5;
      tn_6  <= -tn_5;
    end else begin
      det_6 <= det_5;
      un_6  <= un_5;
      vn_6  <= vn_5;
      tn_6  <= tn_5;
    end

    ok_7 <= (det_6 > DW'($signed({1'b0, min_det})))
         && !un_6[DW-1] && (un_6 <= det_6)
         && !vn_6[DW-1] && (uv_6 <= (DW+1)'(det_6));
    tn_7  <= tn_6;
    mdl_7 <= det_6[DL-1:0] * min_dist;
    mdh_7 <= det_6[DW-1:DL] * min_dist;
  end

  assign push         = vld[NS-1];
  assign verdict.last = lst[NS-1];
  assign verdict.hit  = ok_7 && (rhs_8 < lhs_8);
endmodule

// ----- src/pimr_queue.sv -----
// Verdict queue between front and back, with a credit count so the
// front never has more in flight than the queue can hold. Depends on pimr_pkg.
module pimr_queue #(
  parameter int QDEPTH = pimr_pkg::QDEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic reserve,
  input  logic push,
  input  pimr_pkg::verdict_t wdata,
  input  logic pop,
  output pimr_pkg::verdict_t rdata,
  output pimr_pkg::qstat_t stat
);
  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  pimr_pkg::verdict_t mem [QDEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] fill, pend;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
      pend <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      fill <= fill + CW'(push) - CW'(pop);
      pend <= pend + CW'(reserve) - CW'(pop);
    end
  end

  assign rdata      = mem[rptr];
  assign stat.empty = (fill == '0);
  assign stat.room  = (pend < CW'(QDEPTH));
endmodule

// ----- src/pimr_back.sv -----
// Back end: hit tally, parity and the result register.
// Depends on pimr_pkg.
module pimr_back #(
  parameter int COUNT_BITS = pimr_pkg::COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  pimr_pkg::verdict_t head,
  output logic pop,
  output logic res_valid,
  input  logic res_ready,
  output logic res_inside,
  output logic [pimr_pkg::HITS_W-1:0] res_hits
);
  logic [COUNT_BITS-1:0] tally, tally_next;
  logic odd, odd_next;

  assign pop = head_valid && (!head.last || !res_valid || res_ready);
  assign tally_next = (head.hit && (tally != '1)) ? tally + 1'b1 : tally;
  assign odd_next   = odd ^ head.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      tally     <= '0;
      odd       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pop && head.last) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (pop) begin
        if (head.last) begin
          tally <= '0;
          odd   <= 1'b0;
        end else begin
          tally <= tally_next;
          odd   <= odd_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      res_inside <= odd_next;
      res_hits   <= pimr_pkg::HITS_W'(tally_next);
    end
  end
endmodule

// ----- src/point_in_mesh_ray_parity_unit.sv -----
// Top level of the point-in-mesh ray parity unit.
// Depends on pimr_pkg, pimr_if, pimr_front, pimr_queue and pimr_back.
//
// Usage:
//  - in_ch carries one triangle request per handshake (vertices A, B, C in
//    signed Q16.16, final_tri marks the mesh's last triangle).
//  - out_ch carries one result per mesh: inside_res (odd hit count) and
//    hits (count, saturating at 2^COUNT_BITS-1, low 16 bits shown).
//  - cfg_we/cfg_idx/cfg_data write the query point, min_det and min_dist;
//    write them only while no mesh is in progress.
// Timing:
//  - one triangle per cycle while a credit is free; the 7-stage arithmetic
//    pipeline is the front, then the verdict queue, then the back's result register.
//  - the front takes a request only while the verdict queue has a credit
//    free (QDEPTH requests in flight at most).
// Stall: if out_ch is held off, the back stops at the next final verdict;
//  the queue fills and in_ch.ready drops until the result is taken.
// Reset (rst, synchronous): clears tally, parity, queue and pipeline valids;
//  registers return to point 0, min_det 1, min_dist 1.
module point_in_mesh_ray_parity_unit #(
  parameter int COUNT_BITS = pimr_pkg::COUNT_BITS_DEF,
  parameter int QDEPTH     = pimr_pkg::QDEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  pimr_tri_if.sink   in_ch,
  pimr_res_if.source out_ch,
  input  logic cfg_we,
  input  logic [pimr_pkg::IDX_W-1:0] cfg_idx,
  input  logic [pimr_pkg::CFG_W-1:0] cfg_data
);
  logic signed [pimr_pkg::COORD_W-1:0] qp [3];
  logic [pimr_pkg::MIN_W-1:0] min_det, min_dist;

  logic signed [pimr_pkg::COORD_W-1:0] va [3], vb [3], vc [3];
  logic in_fire, push, pop;
  pimr_pkg::verdict_t verdict, head;
  pimr_pkg::qstat_t qstat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      qp[0]    <= '0;
      qp[1]    <= '0;
      qp[2]    <= '0;
      min_det  <= pimr_pkg::MIN_W'(1);
      min_dist <= pimr_pkg::MIN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pimr_pkg::REG_POINT_X:  qp[0]    <= $signed(cfg_data);
        pimr_pkg::REG_POINT_Y:  qp[1]    <= $signed(cfg_data);
        pimr_pkg::REG_POINT_Z:  qp[2]    <= $signed(cfg_data);
        pimr_pkg::REG_MIN_DET:  min_det  <= cfg_data[pimr_pkg::MIN_W-1:0];
        pimr_pkg::REG_MIN_DIST: min_dist <= cfg_data[pimr_pkg::MIN_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  assign va[0] = in_ch.a_x;
  assign va[1] = in_ch.a_y;
  assign va[2] = in_ch.a_z;
  assign vb[0] = in_ch.b_x;
  assign vb[1] = in_ch.b_y;
  assign vb[2] = in_ch.b_z;
  assign vc[0] = in_ch.c_x;
  assign vc[1] = in_ch.c_y;
  assign vc[2] = in_ch.c_z;

  assign in_ch.ready = qstat.room;
  assign in_fire     = in_ch.valid && qstat.room;

  pimr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .va       (va),
    .vb       (vb),
    .vc       (vc),
    .last_in  (in_ch.final_tri),
    .qp       (qp),
    .min_det  (min_det),
    .min_dist (min_dist),
    .push     (push),
    .verdict  (verdict)
  );

  pimr_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .reserve (in_fire),
    .push    (push),
    .wdata   (verdict),
    .pop     (pop),
    .rdata   (head),
    .stat    (qstat)
  );

  pimr_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!qstat.empty),
    .head       (head),
    .pop        (pop),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res_inside (out_ch.inside_res),
    .res_hits   (out_ch.hits)
  );

  // never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty) else $error("pop from empty verdict queue");

  // a verdict is only pushed while credit was held, so the queue is not empty after
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> !qstat.empty) else $error("pushed verdict lost");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_ch.valid) else $error("result valid out of reset");

  // a held result is not overwritten by the back end
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !(pop && head.last))
    else $error("result register overrun");
endmodule
